// ----- design/l1ac_pkg.sv -----
package l1ac_pkg;

    localparam int M_W   = 9;
    localparam int S_W   = 24;
    localparam int Q_W   = 40;
    localparam int X_W   = 16;
    localparam int WIDE  = 58;
    localparam int VAL_W = 18;

    typedef struct packed {
        logic [M_W-1:0] m;
        logic [S_W-1:0] s;
        logic [Q_W-1:0] q;
        logic [Q_W-1:0] p;
        logic [X_W-1:0] first;
        logic [X_W-1:0] last;
    } t_snap;

endpackage

// ----- design/l1ac_front.sv -----
module l1ac_front #(
    parameter int SERIES_MAX = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [l1ac_pkg::X_W-1:0]   i_sample,
    input  logic                       i_missing,
    input  logic                       i_end,
    output logic                       o_push,
    output l1ac_pkg::t_snap            o_snap
);

    logic [l1ac_pkg::M_W-1:0] r_m, n_m;
    logic [l1ac_pkg::S_W-1:0] r_s, n_s;
    logic [l1ac_pkg::Q_W-1:0] r_q, n_q, r_p, n_p;
    logic [l1ac_pkg::X_W-1:0] r_first, n_first, r_last, n_last;
    logic [l1ac_pkg::X_W-1:0] x;
    logic                     keep;

    always_comb begin
        x = i_sample & l1ac_pkg::X_W'((32'd1 << COUNT_BITS) - 32'd1);
        keep = !i_missing && (r_m < l1ac_pkg::M_W'(SERIES_MAX));
        n_m = r_m;
        n_s = r_s;
        n_q = r_q;
        n_p = r_p;
        n_first = r_first;
        n_last = r_last;
        if (keep) begin
            if (r_m == '0) begin
                n_first = x;
            end else begin
                n_p = r_p + l1ac_pkg::Q_W'(r_last * x);
            end
            n_s = r_s + l1ac_pkg::S_W'(x);
            n_q = r_q + l1ac_pkg::Q_W'(x * x);
            n_last = x;
            n_m = r_m + 1'b1;
        end
    end

    assign o_push = i_accept && i_end;
    assign o_snap = '{m: n_m, s: n_s, q: n_q, p: n_p, first: n_first, last: n_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= '0;
            r_s <= '0;
            r_q <= '0;
            r_p <= '0;
            r_first <= '0;
            r_last <= '0;
        end else if (i_accept) begin
            if (i_end) begin
                r_m <= '0;
                r_s <= '0;
                r_q <= '0;
                r_p <= '0;
                r_first <= '0;
                r_last <= '0;
            end else begin
                r_m <= n_m;
                r_s <= n_s;
                r_q <= n_q;
                r_p <= n_p;
                r_first <= n_first;
                r_last <= n_last;
            end
        end
    end

endmodule

// ----- design/l1ac_fifo.sv -----
module l1ac_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  l1ac_pkg::t_snap i_data,
    input  logic            i_pop,
    output l1ac_pkg::t_snap o_data,
    output logic            o_empty,
    output logic            o_full
);

    l1ac_pkg::t_snap r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ----- design/l1ac_back.sv -----
module l1ac_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  l1ac_pkg::t_snap                     i_snap,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [l1ac_pkg::VAL_W-1:0]   o_value,
    output logic                                o_res_valid
);

    localparam int W = l1ac_pkg::WIDE;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_CLAMP, S_DIV, S_DONE
    } t_state;

    t_state                   r_state;
    l1ac_pkg::t_snap          r_sn;
    logic [W-1:0]             r_mq, r_ss, r_mm, r_ms, r_lin, r_m2p, r_mss, r_negt;
    logic [W-1:0]             r_diff, r_den, r_pos;
    logic [W:0]               r_rem;
    logic [17:0]              r_quo;
    logic [4:0]               r_step;
    logic                     r_neg, r_ok;
    logic [W:0]               rem_sh;
    logic [18:0]              rnd;
    logic [16:0]              mag17;
    logic [l1ac_pkg::S_W:0]   two_s;
    logic [l1ac_pkg::X_W:0]   fl;

    always_comb begin
        rem_sh = {r_rem[W-1:0], 1'b0};
        rnd = {1'b0, r_quo} + 19'd1;
        mag17 = rnd[17:1];
        two_s = {r_sn.s, 1'b0};
        fl = {1'b0, r_sn.first} + {1'b0, r_sn.last};
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_sn <= i_snap;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_mq <= W'(r_sn.m * r_sn.q);
                    r_ss <= W'(r_sn.s * r_sn.s);
                    r_mm <= W'(r_sn.m * r_sn.m);
                    r_ms <= W'(r_sn.m * r_sn.s);
                    r_lin <= (two_s >= (l1ac_pkg::S_W+1)'(fl))
                           ? W'(two_s - (l1ac_pkg::S_W+1)'(fl)) : '0;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_ok <= (r_sn.m >= l1ac_pkg::M_W'(2)) && (r_mq > r_ss);
                    r_diff <= r_mq - r_ss;
                    r_m2p <= W'(r_mm[17:0] * r_sn.p);
                    r_mss <= W'((r_sn.m - 1'b1) * r_ss[47:0]);
                    r_negt <= W'(r_ms[32:0] * r_lin[24:0]);
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_den <= W'(r_sn.m * r_diff[48:0]);
                    r_pos <= r_m2p + r_mss;
                    r_state <= r_ok ? S_CLAMP : S_DONE;
                    r_quo <= '0;
                    r_neg <= 1'b0;
                end
                S_CLAMP: begin
                    // mag clamped to den, so a first quotient bit means exact one
                    if (r_pos >= r_negt) begin
                        r_neg <= 1'b0;
                        if (r_pos - r_negt >= r_den) begin
                            r_quo <= 18'd1;
                            r_rem <= '0;
                        end else begin
                            r_quo <= 18'd0;
                            r_rem <= {1'b0, r_pos - r_negt};
                        end
                    end else begin
                        r_neg <= 1'b1;
                        if (r_negt - r_pos >= r_den) begin
                            r_quo <= 18'd1;
                            r_rem <= '0;
                        end else begin
                            r_quo <= 18'd0;
                            r_rem <= {1'b0, r_negt - r_pos};
                        end
                    end
                    r_step <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= rem_sh - {1'b0, r_den};
                        r_quo <= {r_quo[16:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[16:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd16) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_res_valid <= r_ok;
                        if (!r_ok) begin
                            o_value <= '0;
                        end else if (r_neg) begin
                            o_value <= -$signed({1'b0, mag17});
                        end else begin
                            o_value <= $signed({1'b0, mag17});
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/lag1_autocorrelation_unit.sv -----
// Lag-1 autocorrelation of a stream of unsigned counts. One input word per
// cycle is taken while the queue of finished series has room; missing samples
// (tuser) are skipped and tlast closes the series. Each closed series yields
// one output word after a pop state, three multiply stages, a compare step,
// a 17-step restoring divider taking one quotient bit a cycle, and a state
// that registers the result and waits for the output to take it, all in the
// back unit; a series that gives no valid result skips the compare and the
// divider. The queue holds two closed series, so the input stalls only when
// two of them wait there while the back unit is busy.
module lag1_autocorrelation_unit #(
    parameter int SERIES_MAX = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // sample_count
    input  logic        i_s_axis_tuser,   // sample_missing
    input  logic        i_s_axis_tlast,   // series_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // autocorr_value[17:0], zero pad
    output logic        o_m_axis_tuser    // result_valid
);

    l1ac_pkg::t_snap push_snap, pop_snap;
    logic push, pop, empty, full, accept;
    logic signed [l1ac_pkg::VAL_W-1:0] value;

    assign o_s_axis_tready = !full;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tdata = {6'd0, value};

    l1ac_front #(.SERIES_MAX(SERIES_MAX), .COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_sample(i_s_axis_tdata), .i_missing(i_s_axis_tuser),
        .i_end(i_s_axis_tlast), .o_push(push), .o_snap(push_snap)
    );

    l1ac_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(push_snap),
        .i_pop(pop), .o_data(pop_snap), .o_empty(empty), .o_full(full)
    );

    l1ac_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_snap(pop_snap), .i_empty(empty),
        .o_pop(pop), .o_valid(o_m_axis_tvalid), .i_ready(i_m_axis_tready),
        .o_value(value), .o_res_valid(o_m_axis_tuser)
    );

endmodule

// ----- design/l1ac_checker.sv -----
module l1ac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 24'd0)
        else $error("invalid result carries nonzero value");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[23:18] == 6'd0 &&
        (o_m_axis_tdata[17] == o_m_axis_tdata[16] || o_m_axis_tdata[15:0] == 16'd0))
        else $error("result outside unit range");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output valid or input blocked after reset");

endmodule

bind lag1_autocorrelation_unit l1ac_checker u_l1ac_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_s_axis_tready(o_s_axis_tready), .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready), .o_m_axis_tdata(o_m_axis_tdata),
    .o_m_axis_tuser(o_m_axis_tuser)
);
